### hdl/blt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blt_pkg
// Shared types and constants of the clipped color-key blitter.
// ----------------------------------------------------------------------------
package blt_pkg;

   // command codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_BLIT  = 2'd2;

   // configuration register indexes
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 18;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_BASE   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_STRIDE = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DST_BASE   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DST_STRIDE = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DST_WIDTH  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_DST_HEIGHT = 4'd7;

   // reset values
   localparam logic [17:0] RST_BASE   = 18'd0;
   localparam logic [12:0] RST_STRIDE = 13'd320;
   localparam logic [11:0] RST_WIDTH  = 12'd320;
   localparam logic [11:0] RST_HEIGHT = 12'd200;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_COPY
   } state_type;

   typedef struct packed {
      logic [17:0] src_base;
      logic [12:0] src_stride;
      logic [11:0] src_width;
      logic [11:0] src_height;
      logic [17:0] dst_base;
      logic [12:0] dst_stride;
      logic [11:0] dst_width;
      logic [11:0] dst_height;
   } csr_type;

   // prepared blit geometry
   typedef struct packed {
      logic        reject;
      logic        use_key;
      logic        back;
      logic [11:0] width;
      logic [11:0] height;
   } geom_type;

endpackage
`default_nettype wire

### hdl/blt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module blt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### hdl/blt_geom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blt_geom
// Three-stage setup pipeline for a blit: bounds check, origin clamp and
// clip, start addresses, copy direction and first-pixel anchors.
// ----------------------------------------------------------------------------
module blt_geom #(
   parameter int AW = 18
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     go,
   input  wire blt_pkg::csr_type         csr,
   input  wire logic signed [11:0]       src_col,
   input  wire logic signed [11:0]       src_row,
   input  wire logic signed [11:0]       dst_col,
   input  wire logic signed [11:0]       dst_row,
   input  wire logic signed [12:0]       rect_width,
   input  wire logic signed [12:0]       rect_height,
   input  wire logic                     use_key,
   output logic                          valid,
   output blt_pkg::geom_type             geom,
   output logic [AW-1:0]                 src_anchor,
   output logic [AW-1:0]                 dst_anchor
);

   import blt_pkg::*;

   // stage a
   logic        va_ff;
   logic        rej_a_ff, key_a_ff;
   logic [11:0] w_a_ff, h_a_ff;
   logic [10:0] sc_a_ff, dc_a_ff;
   logic [23:0] ps_a_ff, pd_a_ff;
   // stage b
   logic          vb_ff;
   logic          rej_b_ff, key_b_ff;
   logic [11:0]   w_b_ff, h_b_ff;
   logic [AW-1:0] sa_b_ff, da_b_ff;
   logic [24:0]   ps_b_ff, pd_b_ff;
   // stage c
   logic          vc_ff;
   geom_type      geom_ff;
   logic [AW-1:0] sanc_ff, danc_ff;

   logic        rej_a_in;
   logic [10:0] sc_c, sr_c, dc_c, dr_c;
   logic [13:0] hsum, wsum;
   logic [11:0] h_a_in, w_a_in;
   logic [11:0] wm1;
   logic [AW-1:0] sa_b_in, da_b_in;
   logic          back_in;

   always_comb begin
      rej_a_in = (src_col >= $signed({1'b0, csr.src_width}))
              || (src_row >= $signed({1'b0, csr.src_height}))
              || (dst_col >= $signed({1'b0, csr.dst_width}))
              || (dst_row >= $signed({1'b0, csr.dst_height}))
              || rect_height[12]
              || rect_width[12] || (rect_width == 13'sd0);
      sc_c = src_col[11] ? 11'd0 : src_col[10:0];
      sr_c = src_row[11] ? 11'd0 : src_row[10:0];
      dc_c = dst_col[11] ? 11'd0 : dst_col[10:0];
      dr_c = dst_row[11] ? 11'd0 : dst_row[10:0];
      // clip size to the destination viewport
      hsum = 14'(dr_c) + 14'(rect_height[11:0]);
      wsum = 14'(dc_c) + 14'(rect_width[11:0]);
      h_a_in = (hsum > 14'(csr.dst_height)) ? (csr.dst_height - 12'(dr_c))
                                             : rect_height[11:0];
      w_a_in = (wsum > 14'(csr.dst_width)) ? (csr.dst_width - 12'(dc_c))
                                           : rect_width[11:0];
   end

   always_comb begin
      sa_b_in = AW'(csr.src_base) + AW'(sc_a_ff) + AW'(ps_a_ff);
      da_b_in = AW'(csr.dst_base) + AW'(dc_a_ff) + AW'(pd_a_ff);
      wm1     = w_b_ff - 12'd1;
      back_in = sa_b_ff < da_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= go;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      rej_a_ff <= rej_a_in;
      key_a_ff <= use_key;
      w_a_ff   <= w_a_in;
      h_a_ff   <= h_a_in;
      sc_a_ff  <= sc_c;
      dc_a_ff  <= dc_c;
      ps_a_ff  <= 24'(sr_c) * 24'(csr.src_stride);
      pd_a_ff  <= 24'(dr_c) * 24'(csr.dst_stride);

      rej_b_ff <= rej_a_ff;
      key_b_ff <= key_a_ff;
      w_b_ff   <= w_a_ff;
      h_b_ff   <= h_a_ff;
      sa_b_ff  <= sa_b_in;
      da_b_ff  <= da_b_in;
      ps_b_ff  <= (25'(h_a_ff) - 25'd1) * 25'(csr.src_stride);
      pd_b_ff  <= (25'(h_a_ff) - 25'd1) * 25'(csr.dst_stride);

      geom_ff.reject  <= rej_b_ff;
      geom_ff.use_key <= key_b_ff;
      geom_ff.back    <= back_in;
      geom_ff.width   <= w_b_ff;
      geom_ff.height  <= h_b_ff;
      // bottom-right pixel first when copying backward
      if (back_in) begin
         sanc_ff <= sa_b_ff + AW'(ps_b_ff) + AW'(wm1);
         danc_ff <= da_b_ff + AW'(pd_b_ff) + AW'(wm1);
      end else begin
         sanc_ff <= sa_b_ff;
         danc_ff <= da_b_ff;
      end
   end

   assign valid      = vc_ff;
   assign geom       = geom_ff;
   assign src_anchor = sanc_ff;
   assign dst_anchor = danc_ff;

endmodule
`default_nettype wire

### hdl/blt_copy.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blt_copy
// Pixel copy engine: one frame memory read per cycle, write-back in the cycle
// after the read, with forwarding when a read hits the address being written.
// ----------------------------------------------------------------------------
module blt_copy #(
   parameter int AW = 18
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire blt_pkg::geom_type geom,
   input  wire logic [AW-1:0]     src_anchor,
   input  wire logic [AW-1:0]     dst_anchor,
   input  wire logic [12:0]       src_stride,
   input  wire logic [12:0]       dst_stride,
   input  wire logic [7:0]        rd_data,
   output logic                   rd_en,
   output logic [AW-1:0]          rd_addr,
   output logic                   wr_en,
   output logic [AW-1:0]          wr_addr,
   output logic [7:0]             wr_data,
   output logic                   done
);

   import blt_pkg::*;

   logic          active_ff, pend_ff, hit_ff, done_ff;
   logic          back_ff, key_ff;
   logic [11:0]   wlast_ff, xcnt_ff, ycnt_ff;
   logic [AW-1:0] sp_ff, dp_ff, sanc_ff, danc_ff, pend_addr_ff;
   logic [7:0]    fwd_ff;

   logic          empty, row_end, last, hit_in;
   logic [AW-1:0] sanc_in, danc_in;
   logic [7:0]    pix;

   always_comb begin
      empty   = (geom.width == 12'd0) || (geom.height == 12'd0);
      row_end = xcnt_ff == 12'd0;
      last    = row_end && (ycnt_ff == 12'd0);
      sanc_in = back_ff ? sanc_ff - AW'(src_stride) : sanc_ff + AW'(src_stride);
      danc_in = back_ff ? danc_ff - AW'(dst_stride) : danc_ff + AW'(dst_stride);
      pix     = hit_ff ? fwd_ff : rd_data;
      wr_en   = pend_ff && (!key_ff || (pix != 8'd0));
      hit_in  = wr_en && active_ff && (sp_ff == pend_addr_ff);
   end

   assign rd_en   = active_ff;
   assign rd_addr = sp_ff;
   assign wr_addr = pend_addr_ff;
   assign wr_data = pix;
   assign done    = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         hit_ff    <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         pend_ff <= active_ff;
         hit_ff  <= hit_in;
         // last write goes out in the cycle after the last read
         done_ff <= (pend_ff && !active_ff) || (start && empty);
         if (start) begin
            active_ff <= !empty;
         end else if (active_ff && last) begin
            active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= dp_ff;
      fwd_ff       <= pix;
      if (start) begin
         back_ff  <= geom.back;
         key_ff   <= geom.use_key;
         wlast_ff <= geom.width - 12'd1;
         xcnt_ff  <= geom.width - 12'd1;
         ycnt_ff  <= geom.height - 12'd1;
         sanc_ff  <= src_anchor;
         danc_ff  <= dst_anchor;
         sp_ff    <= src_anchor;
         dp_ff    <= dst_anchor;
      end else if (active_ff) begin
         if (row_end) begin
            sanc_ff <= sanc_in;
            danc_ff <= danc_in;
            sp_ff   <= sanc_in;
            dp_ff   <= danc_in;
            xcnt_ff <= wlast_ff;
            ycnt_ff <= ycnt_ff - 12'd1;
         end else begin
            sp_ff   <= back_ff ? sp_ff - AW'(1) : sp_ff + AW'(1);
            dp_ff   <= back_ff ? dp_ff - AW'(1) : dp_ff + AW'(1);
            xcnt_ff <= xcnt_ff - 12'd1;
         end
      end
   end

endmodule
`default_nettype wire

### hdl/clipped_color_key_blitter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_color_key_blitter_top
// 2D blitter over an internal byte-per-pixel frame memory with pixel write,
// pixel read and clipped, color-keyed rectangle copy.
// ----------------------------------------------------------------------------
// pixel write / read: result in the cycle after accept, a new command every cycle while idle
// blit: setup pipeline, one read per pixel (width*height after clip) with keyed write-back,
//   then the result (right after setup if nothing is copied); paced by the single frame memory read port
// a rejected blit answers right after setup; result strobe lasts one cycle, no stall
// reset clears control state and restores register defaults; frame memory is
//   not cleared and holds undefined bytes until written
module clipped_color_key_blitter_top #(
   parameter int FRAME_BYTES = 262144
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [1:0]                     req_opcode,
   input  wire logic [17:0]                    req_address,
   input  wire logic [7:0]                     req_pixel_value,
   input  wire logic signed [11:0]             req_src_col,
   input  wire logic signed [11:0]             req_src_row,
   input  wire logic signed [11:0]             req_dst_col,
   input  wire logic signed [11:0]             req_dst_row,
   input  wire logic signed [12:0]             req_rect_width,
   input  wire logic signed [12:0]             req_rect_height,
   input  wire logic                           req_use_key,
   output logic                                rsp_valid,
   output logic [7:0]                          rsp_read_data,
   output logic                                rsp_status,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [blt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [blt_pkg::CSR_DAT_W-1:0]  csr_wdata
);

   import blt_pkg::*;

   localparam int AW = $clog2(FRAME_BYTES);

   state_type state_ff, state_in;
   csr_type   csr_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_status_ff, rsp_status_in;
   logic      rd_sel_ff, rd_sel_in;

   logic      accept, geom_go, copy_start;
   logic      geom_valid, copy_done;
   geom_type  geom;
   logic [AW-1:0] src_anchor, dst_anchor;

   logic          copy_rd_en, copy_wr_en;
   logic [AW-1:0] copy_rd_addr, copy_wr_addr;
   logic [7:0]    copy_wr_data;

   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]    ram_wr_data, ram_rd_data;

   assign accept    = start && !busy;
   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == OP_BLIT)) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (geom_valid) begin
               state_in = geom.reject ? ST_IDLE : ST_COPY;
            end
         end
         ST_COPY: begin
            if (copy_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the controller
   always_comb begin
      geom_go       = 1'b0;
      copy_start    = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = 1'b0;
      rd_sel_in     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_BLIT: geom_go = 1'b1;
                  OP_READ: begin
                     rsp_valid_in = 1'b1;
                     rd_sel_in    = 1'b1;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_SETUP: begin
            if (geom_valid) begin
               if (geom.reject) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = 1'b1;
               end else begin
                  copy_start = 1'b1;
               end
            end
         end
         ST_COPY: begin
            rsp_valid_in = copy_done;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= 1'b0;
         rd_sel_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rd_sel_ff     <= rd_sel_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.src_base   <= RST_BASE;
         csr_ff.src_stride <= RST_STRIDE;
         csr_ff.src_width  <= RST_WIDTH;
         csr_ff.src_height <= RST_HEIGHT;
         csr_ff.dst_base   <= RST_BASE;
         csr_ff.dst_stride <= RST_STRIDE;
         csr_ff.dst_width  <= RST_WIDTH;
         csr_ff.dst_height <= RST_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SRC_BASE:   csr_ff.src_base   <= csr_wdata[17:0];
            REG_SRC_STRIDE: csr_ff.src_stride <= csr_wdata[12:0];
            REG_SRC_WIDTH:  csr_ff.src_width  <= csr_wdata[11:0];
            REG_SRC_HEIGHT: csr_ff.src_height <= csr_wdata[11:0];
            REG_DST_BASE:   csr_ff.dst_base   <= csr_wdata[17:0];
            REG_DST_STRIDE: csr_ff.dst_stride <= csr_wdata[12:0];
            REG_DST_WIDTH:  csr_ff.dst_width  <= csr_wdata[11:0];
            REG_DST_HEIGHT: csr_ff.dst_height <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   blt_geom #(
      .AW(AW)
   ) u_geom (
      .clock       (clock),
      .reset       (reset),
      .go          (geom_go),
      .csr         (csr_ff),
      .src_col     (req_src_col),
      .src_row     (req_src_row),
      .dst_col     (req_dst_col),
      .dst_row     (req_dst_row),
      .rect_width  (req_rect_width),
      .rect_height (req_rect_height),
      .use_key     (req_use_key),
      .valid       (geom_valid),
      .geom        (geom),
      .src_anchor  (src_anchor),
      .dst_anchor  (dst_anchor)
   );

   blt_copy #(
      .AW(AW)
   ) u_copy (
      .clock      (clock),
      .reset      (reset),
      .start      (copy_start),
      .geom       (geom),
      .src_anchor (src_anchor),
      .dst_anchor (dst_anchor),
      .src_stride (csr_ff.src_stride),
      .dst_stride (csr_ff.dst_stride),
      .rd_data    (ram_rd_data),
      .rd_en      (copy_rd_en),
      .rd_addr    (copy_rd_addr),
      .wr_en      (copy_wr_en),
      .wr_addr    (copy_wr_addr),
      .wr_data    (copy_wr_data),
      .done       (copy_done)
   );

   // frame memory port sharing: host pixel commands only while idle
   always_comb begin
      if (copy_wr_en) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = copy_wr_addr;
         ram_wr_data = copy_wr_data;
      end else begin
         ram_wr_en   = accept && (req_opcode == OP_WRITE);
         ram_wr_addr = AW'(req_address);
         ram_wr_data = req_pixel_value;
      end
      if (copy_rd_en) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = copy_rd_addr;
      end else begin
         ram_rd_en   = accept && (req_opcode == OP_READ);
         ram_rd_addr = AW'(req_address);
      end
   end

   blt_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES)
   ) u_frame (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_data = rd_sel_ff ? ram_rd_data : 8'd0;

endmodule
`default_nettype wire
